/* hdl/bbce_pkg.sv */
// ----------------------------------------------------------------------------
// bbce_pkg
// Shared constants, codes and types of the bitblt copy/xor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package bbce_pkg;

  localparam int MEM_ADDR_BITS     = 20;
  localparam int MEM_SIZE          = 2 ** MEM_ADDR_BITS;
  localparam int ADDR_IN_BITS      = 20;
  localparam int PATTERN_ROW_BYTES = 16;
  localparam int PATTERN_ROWS      = 8;
  localparam int PBYTE_BITS        = $clog2(PATTERN_ROW_BYTES);
  localparam int PROW_BITS         = $clog2(PATTERN_ROWS);
  localparam int SUM_BITS          = (MEM_ADDR_BITS > 16 ? MEM_ADDR_BITS : 16) + 2;

  localparam logic [7:0] ROP_COPY = 8'h0d;
  localparam logic [7:0] ROP_XOR  = 8'h59;
  localparam int MODE_REVERSE_BIT = 0;
  localparam int MODE_PATTERN_BIT = 6;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_BLIT  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_BLIT_WIDTH   = 3'd0,
    REG_BLIT_HEIGHT  = 3'd1,
    REG_SOURCE_PITCH = 3'd2,
    REG_TARGET_PITCH = 3'd3,
    REG_SOURCE_START = 3'd4,
    REG_TARGET_START = 3'd5,
    REG_BLIT_MODE    = 3'd6,
    REG_RASTER_OP    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WR_BYTE,
    ST_NOP,
    ST_RD_BYTE,
    ST_RD_WAIT,
    ST_BLIT_INIT,
    ST_ROW_PAT,
    ST_ROW_SRC,
    ST_ROW_TGT,
    ST_RD_SRC,
    ST_RD_TGT,
    ST_WR_TGT,
    ST_STEP_SRC,
    ST_STEP_TGT
  } state_t;

  typedef struct packed {
    logic [15:0] blit_width;
    logic [15:0] blit_height;
    logic [15:0] source_pitch;
    logic [15:0] target_pitch;
    logic [19:0] source_start;
    logic [19:0] target_start;
    logic [7:0]  blit_mode;
    logic [7:0]  raster_op;
  } cfg_t;

  typedef struct packed {
    logic [MEM_ADDR_BITS-1:0] a;
    logic [15:0]              b;
    logic                     sub;
  } alu_in_t;

  typedef struct packed {
    logic [MEM_ADDR_BITS-1:0] sum;
    logic                     fits;
    logic                     borrow;
  } alu_out_t;

  typedef struct packed {
    logic                     we;
    logic [MEM_ADDR_BITS-1:0] waddr;
    logic [7:0]               wdata;
    logic [MEM_ADDR_BITS-1:0] raddr;
  } ram_req_t;

  function automatic logic [MEM_ADDR_BITS-1:0] to_maddr(input logic [ADDR_IN_BITS-1:0] a);
    logic [MEM_ADDR_BITS+ADDR_IN_BITS-1:0] wide;
    wide = {{MEM_ADDR_BITS{1'b0}}, a};
    return wide[MEM_ADDR_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/bbce_ram.sv */
// ----------------------------------------------------------------------------
// bbce_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/bbce_alu.sv */
// ----------------------------------------------------------------------------
// bbce_alu
// Shared address adder/subtracter with memory-top and borrow flags.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_alu (
  input  bbce_pkg::alu_in_t  alu_in,
  output bbce_pkg::alu_out_t alu_out
);

  import bbce_pkg::*;

  logic [SUM_BITS-1:0] ext_a;
  logic [SUM_BITS-1:0] ext_b;
  logic [SUM_BITS-1:0] res;

  always_comb begin
    ext_a = SUM_BITS'(alu_in.a);
    ext_b = SUM_BITS'(alu_in.b);
    if (alu_in.sub) begin
      res = ext_a - ext_b;
    end else begin
      res = ext_a + ext_b;
    end
    alu_out.sum    = res[MEM_ADDR_BITS-1:0];
    alu_out.fits   = (res[SUM_BITS-1:MEM_ADDR_BITS] == '0);
    alu_out.borrow = res[SUM_BITS-1];
  end

endmodule

`default_nettype wire

/* hdl/bbce_seq.sv */
// ----------------------------------------------------------------------------
// bbce_seq
// Command and blit sequencer: drives the shared address unit and the RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module bbce_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          mode,
  input  logic [bbce_pkg::ADDR_IN_BITS-1:0]   address,
  input  logic [7:0]                          data,
  input  bbce_pkg::cfg_t                      cfg,
  output bbce_pkg::alu_in_t                   alu_in,
  input  bbce_pkg::alu_out_t                  alu_out,
  output bbce_pkg::ram_req_t                  ram_req,
  input  logic [7:0]                          ram_rdata,
  output logic                                result_valid,
  output logic [7:0]                          read_data,
  output logic                                blit_done
);

  import bbce_pkg::*;

  state_t state;
  state_t state_next;

  logic [MEM_ADDR_BITS-1:0] cmd_addr;
  logic [7:0]               cmd_data;
  logic [MEM_ADDR_BITS-1:0] row_src;
  logic [MEM_ADDR_BITS-1:0] row_tgt;
  logic [MEM_ADDR_BITS-1:0] cur_src;
  logic [MEM_ADDR_BITS-1:0] cur_tgt;
  logic [15:0]              row_cnt;
  logic [15:0]              byte_cnt;
  logic                     row_ok;
  logic [7:0]               sbyte;

  logic        accept;
  logic        pat;
  logic        rev;
  logic        rop_xor;
  logic        rop_ok;
  logic        src_ok;
  logic        fire;
  logic        fire_rd;
  logic        fire_blit;
  logic [15:0] plen_m1;
  logic [15:0] pat_offset;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && (state == ST_IDLE);
  assign pat     = cfg.blit_mode[MODE_PATTERN_BIT];
  assign rev     = cfg.blit_mode[MODE_REVERSE_BIT] && !pat;
  assign rop_xor = (cfg.raster_op == ROP_XOR);
  assign rop_ok  = (cfg.raster_op == ROP_COPY) || rop_xor;
  assign src_ok  = rev ? !alu_out.borrow : alu_out.fits;
  assign plen_m1 = (cfg.blit_width > 16'(PATTERN_ROW_BYTES - 1)) ?
                   16'(PATTERN_ROW_BYTES - 1) : cfg.blit_width;
  assign pat_offset = 16'({row_cnt[PROW_BITS-1:0], {PBYTE_BITS{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    alu_in        = '{a: '0, b: '0, sub: 1'b0};
    ram_req.we    = 1'b0;
    ram_req.waddr = cmd_addr;
    ram_req.wdata = cmd_data;
    ram_req.raddr = cmd_addr;
    fire          = 1'b0;
    fire_rd       = 1'b0;
    fire_blit     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(mode))
            CMD_WRITE: state_next = ST_WR_BYTE;
            CMD_READ:  state_next = ST_RD_BYTE;
            CMD_BLIT:  state_next = ST_BLIT_INIT;
            default:   state_next = ST_NOP;
          endcase
        end
      end
      ST_WR_BYTE: begin
        ram_req.we = 1'b1;
        fire       = 1'b1;
        state_next = ST_IDLE;
      end
      ST_NOP: begin
        fire       = 1'b1;
        state_next = ST_IDLE;
      end
      ST_RD_BYTE: begin
        state_next = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        fire       = 1'b1;
        fire_rd    = 1'b1;
        state_next = ST_IDLE;
      end
      ST_BLIT_INIT: begin
        if (!rop_ok) begin
          fire       = 1'b1;
          fire_blit  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = pat ? ST_ROW_PAT : ST_ROW_SRC;
        end
      end
      ST_ROW_PAT: begin
        alu_in     = '{a: to_maddr(cfg.source_start), b: pat_offset, sub: 1'b0};
        state_next = ST_ROW_SRC;
      end
      ST_ROW_SRC: begin
        alu_in     = '{a: row_src, b: (pat ? plen_m1 : cfg.blit_width), sub: rev};
        state_next = ST_ROW_TGT;
      end
      ST_ROW_TGT: begin
        alu_in = '{a: row_tgt, b: cfg.blit_width, sub: rev};
        if (row_ok && src_ok) begin
          state_next = ST_RD_SRC;
        end else begin
          state_next = pat ? ST_STEP_TGT : ST_STEP_SRC;
        end
      end
      ST_RD_SRC: begin
        ram_req.raddr = cur_src;
        alu_in        = '{a: cur_src, b: 16'd1, sub: rev};
        state_next    = rop_xor ? ST_RD_TGT : ST_WR_TGT;
      end
      ST_RD_TGT: begin
        ram_req.raddr = cur_tgt;
        state_next    = ST_WR_TGT;
      end
      ST_WR_TGT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cur_tgt;
        ram_req.wdata = rop_xor ? (sbyte ^ ram_rdata) : ram_rdata;
        alu_in        = '{a: cur_tgt, b: 16'd1, sub: rev};
        if (byte_cnt == cfg.blit_width) begin
          state_next = pat ? ST_STEP_TGT : ST_STEP_SRC;
        end else begin
          state_next = ST_RD_SRC;
        end
      end
      ST_STEP_SRC: begin
        alu_in     = '{a: row_src, b: cfg.source_pitch, sub: rev};
        state_next = ST_STEP_TGT;
      end
      ST_STEP_TGT: begin
        alu_in = '{a: row_tgt, b: cfg.target_pitch, sub: rev};
        if (row_cnt == cfg.blit_height) begin
          fire       = 1'b1;
          fire_blit  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = pat ? ST_ROW_PAT : ST_ROW_SRC;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd_addr <= to_maddr(address);
          cmd_data <= data;
        end
      end
      ST_BLIT_INIT: begin
        row_cnt <= '0;
        row_src <= to_maddr(cfg.source_start);
        row_tgt <= to_maddr(cfg.target_start);
      end
      ST_ROW_PAT: begin
        row_src <= alu_out.sum;
      end
      ST_ROW_SRC: begin
        row_ok <= src_ok;
      end
      ST_ROW_TGT: begin
        cur_src  <= row_src;
        cur_tgt  <= row_tgt;
        byte_cnt <= '0;
      end
      ST_RD_SRC: begin
        if (pat && (byte_cnt[PBYTE_BITS-1:0] == '1)) begin
          cur_src <= row_src;
        end else begin
          cur_src <= alu_out.sum;
        end
      end
      ST_RD_TGT: begin
        sbyte <= ram_rdata;
      end
      ST_WR_TGT: begin
        cur_tgt  <= alu_out.sum;
        byte_cnt <= byte_cnt + 16'd1;
      end
      ST_STEP_SRC: begin
        row_src <= alu_out.sum;
      end
      ST_STEP_TGT: begin
        row_tgt <= alu_out.sum;
        row_cnt <= row_cnt + 16'd1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data <= fire_rd ? ram_rdata : 8'h00;
      blit_done <= fire_blit;
    end
  end

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe held for two cycles");

  a_blit_no_data: assert property (@(posedge clk) disable iff (rst)
    (result_valid && blit_done) |-> (read_data == 8'h00))
    else $error("blit result carries read data");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_byte_in_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD_SRC) |-> (byte_cnt <= cfg.blit_width))
    else $error("byte counter ran past the row");

endmodule

`default_nettype wire

/* hdl/bitblt_copy_xor_engine_top.sv */
// ----------------------------------------------------------------------------
// bitblt_copy_xor_engine_top
// Byte-wide video memory with a 2-D copy/xor block transfer engine.
//
//   channel   signals                                   direction
//   command   start, busy, mode, address, data          in (busy out)
//   result    result_valid, read_data, blit_done        out
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// Write, read and unused commands all go through the one RAM port pair.
// A blit sets up and reports, and per row runs the bound checks (after a
// pattern row offset step in pattern mode) and pitch stepping (target only
// in pattern mode), plus a source read and a target write per byte, with a
// target read between them for xor, one adder doing every address step.
// Reset clears control state and the registers; memory is not cleared.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bitblt_copy_xor_engine_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        mode,
  input  logic [bbce_pkg::ADDR_IN_BITS-1:0] address,
  input  logic [7:0]                        data,
  output logic                              result_valid,
  output logic [7:0]                        read_data,
  output logic                              blit_done,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [19:0]                       cfg_data
);

  import bbce_pkg::*;

  cfg_t     cfg;
  alu_in_t  alu_in;
  alu_out_t alu_out;
  ram_req_t ram_req;
  logic [7:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_BLIT_WIDTH:   cfg.blit_width   <= cfg_data[15:0];
        REG_BLIT_HEIGHT:  cfg.blit_height  <= cfg_data[15:0];
        REG_SOURCE_PITCH: cfg.source_pitch <= cfg_data[15:0];
        REG_TARGET_PITCH: cfg.target_pitch <= cfg_data[15:0];
        REG_SOURCE_START: cfg.source_start <= cfg_data;
        REG_TARGET_START: cfg.target_start <= cfg_data;
        REG_BLIT_MODE:    cfg.blit_mode    <= cfg_data[7:0];
        REG_RASTER_OP:    cfg.raster_op    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  bbce_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  bbce_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .address      (address),
    .data         (data),
    .cfg          (cfg),
    .alu_in       (alu_in),
    .alu_out      (alu_out),
    .ram_req      (ram_req),
    .ram_rdata    (ram_rdata),
    .result_valid (result_valid),
    .read_data    (read_data),
    .blit_done    (blit_done)
  );

  bbce_ram #(
    .WIDTH (8),
    .DEPTH (MEM_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bitblt copy/xor engine. Byte writes, byte
// reads and blits are queued in phases, each phase opening with a full set
// of engine register writes. Before every blit, the bytes it will fetch are
// written first so no unwritten byte is ever read. A byte-level model of the
// video memory and the blit walk predicts every result, which is checked
// field by field as the strobe arrives. Random gaps on the command side.
// ----------------------------------------------------------------------------

module testbench;
  import bbce_pkg::*;

  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned ADDR_MASK      = MEM_SIZE - 1;
  localparam logic [7:0]  WALK_REVERSE   = 8'(1 << MODE_REVERSE_BIT);
  localparam logic [7:0]  WALK_PATTERN   = 8'(1 << MODE_PATTERN_BIT);
  localparam int          WATCHDOG_LIMIT = 2000000;
  localparam int          RANDOM_ITEMS   = 400;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [19:0] addr;
    logic [7:0]  data;
  } blit_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       blit_done;
  } response_t;

  typedef struct packed {
    logic [31:0] tgt;
    logic [31:0] src;
  } byte_move_t;

  logic        clk;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic [1:0]  mode       = CMD_WRITE;
  logic [19:0] address    = '0;
  logic [7:0]  data       = '0;
  logic        cfg_valid  = 1'b0;
  logic [2:0]  cfg_index  = REG_BLIT_WIDTH;
  logic [19:0] cfg_data   = '0;
  logic        busy;
  logic        result_valid;
  logic [7:0]  read_data;
  logic        blit_done;
  logic        cfg_ready;

  blit_item_t  command_backlog[$];
  response_t   pending_responses[$];
  blit_item_t  issuing;
  int unsigned gap_left    = 0;
  bit          burst       = 1'b0;
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  int          queued_total = 0;

  cfg_t        blit_regs = '0;
  logic [7:0]  vram_model [int unsigned];
  bit          seeded_bytes [int unsigned];
  int unsigned seeded_list[$];

  bitblt_copy_xor_engine_top dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .address      (address),
    .data         (data),
    .result_valid (result_valid),
    .read_data    (read_data),
    .blit_done    (blit_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Byte moves of one blit in walk order; empty for a raster op that does nothing.
  function automatic void walk_blit(input cfg_t regs, ref byte_move_t moves[$]);
    int unsigned w, src, tgt, ps, plen, row, i;
    bit          pattern, rev, take;
    byte_move_t  mv;
    moves.delete();
    if (regs.raster_op != ROP_COPY && regs.raster_op != ROP_XOR) return;
    w       = regs.blit_width;
    src     = regs.source_start & ADDR_MASK;
    tgt     = regs.target_start & ADDR_MASK;
    pattern = regs.blit_mode[MODE_PATTERN_BIT];
    rev     = !pattern && regs.blit_mode[MODE_REVERSE_BIT];
    ps      = 0;
    for (row = 0; row <= regs.blit_height; row++) begin
      if (pattern) begin
        ps   = (regs.source_start + (row % PATTERN_ROWS) * PATTERN_ROW_BYTES) & ADDR_MASK;
        plen = (w + 1 < PATTERN_ROW_BYTES) ? w + 1 : PATTERN_ROW_BYTES;
        take = (ps + plen - 1 < MEM_SIZE) && (tgt + w < MEM_SIZE);
      end else if (rev) begin
        take = (src >= w) && (tgt >= w);
      end else begin
        take = (src + w < MEM_SIZE) && (tgt + w < MEM_SIZE);
      end
      if (take) begin
        for (i = 0; i <= w; i++) begin
          mv.tgt = rev ? tgt - i : tgt + i;
          mv.src = pattern ? ps + i % PATTERN_ROW_BYTES : (rev ? src - i : src + i);
          moves.push_back(mv);
        end
      end
      if (rev) begin
        src = (src - regs.source_pitch) & ADDR_MASK;
        tgt = (tgt - regs.target_pitch) & ADDR_MASK;
      end else begin
        src = (src + regs.source_pitch) & ADDR_MASK;
        tgt = (tgt + regs.target_pitch) & ADDR_MASK;
      end
    end
  endfunction

  function automatic response_t engine_response(input blit_item_t it);
    response_t  r;
    byte_move_t moves[$];
    logic [7:0] s;
    r = '0;
    case (it.cmd)
      CMD_WRITE: vram_model[it.addr] = it.data;
      CMD_READ:  r.read_data = vram_model.exists(it.addr) ? vram_model[it.addr] : 8'h00;
      CMD_BLIT: begin
        walk_blit(blit_regs, moves);
        foreach (moves[k]) begin
          s = vram_model.exists(moves[k].src) ? vram_model[moves[k].src] : 8'h00;
          if (blit_regs.raster_op == ROP_XOR)
            s ^= vram_model.exists(moves[k].tgt) ? vram_model[moves[k].tgt] : 8'h00;
          vram_model[moves[k].tgt] = s;
        end
        r.blit_done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic load_next();
    issuing = command_backlog.pop_front();
    mode    <= issuing.cmd;
    address <= issuing.addr;
    data    <= issuing.data;
  endtask

  always @(posedge clk) begin : drive_items
    int unsigned gap;
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (start && !busy) begin
      pending_responses.push_back(engine_response(issuing));
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap == 0 && command_backlog.size() != 0) begin
        load_next();
      end else begin
        start    <= 1'b0;
        gap_left <= (gap == 0) ? 0 : gap - 1;
      end
    end else if (!start) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (command_backlog.size() != 0) begin
        load_next();
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    response_t want;
    if (!rst && result_valid) begin
      if (pending_responses.size() == 0) begin
        $error("result strobe with no item outstanding");
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        if (read_data !== want.read_data) begin
          $error("read_data: expected %02h, got %02h", want.read_data, read_data);
          mismatch_count++;
        end
        if (blit_done !== want.blit_done) begin
          $error("blit_done: expected %0d, got %0d", want.blit_done, blit_done);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void mark_seeded(input int unsigned a);
    if (!seeded_bytes.exists(a)) begin
      seeded_bytes[a] = 1'b1;
      seeded_list.push_back(a);
    end
  endfunction

  function automatic void queue_item(input logic [1:0] cmd, input int unsigned a,
                                     input logic [7:0] d);
    blit_item_t it;
    it.cmd  = cmd;
    it.addr = a[19:0];
    it.data = d;
    command_backlog.push_back(it);
    if (cmd == CMD_WRITE) mark_seeded(a & ADDR_MASK);
    if (cmd != CMD_UNUSED) queued_total++;
  endfunction

  function automatic int unsigned pick_addr();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 3) return $urandom_range(0, ADDR_MASK);
    if (r < 8) return ADDR_MASK - $urandom_range(0, 511);
    return $urandom_range(0, 511);
  endfunction

  // Seed every byte the blit fetches, then the blit, then read back some targets.
  function automatic void plan_blit(input int n_reads);
    byte_move_t moves[$];
    walk_blit(blit_regs, moves);
    foreach (moves[k]) begin
      if (!seeded_bytes.exists(moves[k].src))
        queue_item(CMD_WRITE, moves[k].src, 8'($urandom));
      if (blit_regs.raster_op == ROP_XOR && !seeded_bytes.exists(moves[k].tgt))
        queue_item(CMD_WRITE, moves[k].tgt, 8'($urandom));
      mark_seeded(moves[k].tgt);
    end
    queue_item(CMD_BLIT, $urandom_range(0, ADDR_MASK), 8'($urandom));
    if (moves.size() != 0)
      repeat (n_reads)
        queue_item(CMD_READ, moves[$urandom_range(0, moves.size() - 1)].tgt, 8'($urandom));
  endfunction

  function automatic void noise_item();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4)
      queue_item(CMD_WRITE, pick_addr(), 8'($urandom));
    else if (r < 8 && seeded_list.size() != 0)
      queue_item(CMD_READ, seeded_list[$urandom_range(0, seeded_list.size() - 1)],
                 8'($urandom));
    else
      queue_item(CMD_UNUSED, $urandom_range(0, ADDR_MASK), 8'($urandom));
  endfunction

  task automatic settle(input int tail);
    while (command_backlog.size() != 0 || start || pending_responses.size() != 0)
      @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [19:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BLIT_WIDTH:   blit_regs.blit_width   = value[15:0];
      REG_BLIT_HEIGHT:  blit_regs.blit_height  = value[15:0];
      REG_SOURCE_PITCH: blit_regs.source_pitch = value[15:0];
      REG_TARGET_PITCH: blit_regs.target_pitch = value[15:0];
      REG_SOURCE_START: blit_regs.source_start = value;
      REG_TARGET_START: blit_regs.target_start = value;
      REG_BLIT_MODE:    blit_regs.blit_mode    = value[7:0];
      REG_RASTER_OP:    blit_regs.raster_op    = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [19:0] w, input logic [19:0] h,
                          input logic [19:0] sp, input logic [19:0] tp,
                          input logic [19:0] ss, input logic [19:0] ts,
                          input logic [19:0] bm, input logic [19:0] rop);
    settle(4);
    write_reg(REG_BLIT_WIDTH, w);
    write_reg(REG_BLIT_HEIGHT, h);
    write_reg(REG_SOURCE_PITCH, sp);
    write_reg(REG_TARGET_PITCH, tp);
    write_reg(REG_SOURCE_START, ss);
    write_reg(REG_TARGET_START, ts);
    write_reg(REG_BLIT_MODE, bm);
    write_reg(REG_RASTER_OP, rop);
  endtask

  function automatic logic [19:0] pick_pitch();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return 20'($urandom_range(0, 64));
    if (r < 8) return 20'($urandom_range(0, 20'hfffff));
    if (r < 9) return 20'h0;
    return 20'h0ffff;
  endfunction

  initial begin
    int          random_goal;
    logic [19:0] rop;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: raster op 0, so the blit leaves memory alone
    queue_item(CMD_WRITE, 20'h00000, 8'h00);
    queue_item(CMD_WRITE, 20'hfffff, 8'hff);
    queue_item(CMD_WRITE, 20'h55555, 8'haa);
    queue_item(CMD_WRITE, 20'haaaaa, 8'h55);
    queue_item(CMD_READ, 20'h00000, 8'hff);
    queue_item(CMD_READ, 20'hfffff, 8'h00);
    queue_item(CMD_READ, 20'h55555, 8'h00);
    queue_item(CMD_READ, 20'haaaaa, 8'h00);
    queue_item(CMD_UNUSED, 20'hfffff, 8'hff);
    queue_item(CMD_BLIT, 20'hfffff, 8'hff);
    queue_item(CMD_READ, 20'hfffff, 8'h00);

    // overlapping forward copy
    set_regs(20'd5, 20'd1, 20'd8, 20'd8, 20'h00010, 20'h00012, 20'h0, ROP_COPY);
    plan_blit(2);
    // reverse xor, last row runs below zero, target pitch wraps
    set_regs(20'd3, 20'd2, 20'd2, 20'h0ffff, 20'h00005, 20'h00030, WALK_REVERSE, ROP_XOR);
    plan_blit(2);
    set_regs(20'd3, 20'd1, 20'd0, 20'h20, 20'h00100, 20'h00200, WALK_PATTERN, ROP_COPY);
    plan_blit(2);
    // rows past the top of memory are skipped, target wraps
    set_regs(20'd2, 20'd2, 20'd1, 20'h100, 20'hffffd, 20'hfff00, 20'h0, ROP_XOR);
    plan_blit(2);
    set_regs(20'hfffff, 20'd0, 20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff, 20'hff, ROP_COPY);
    plan_blit(0);
    set_regs(20'd1, 20'hffff, 20'd0, 20'd0, 20'hfffff, 20'h0, 20'h0, ROP_XOR);
    plan_blit(0);
    queue_item(CMD_READ, 20'hfffff, 8'h00);
    set_regs(20'd0, 20'd0, 20'd0, 20'd0, 20'h0, 20'h0, 20'h0, ROP_COPY);
    plan_blit(1);
    set_regs(20'd2, 20'd1, 20'd3, 20'd3, 20'h00040, 20'h00080, 20'h0, 20'hff);
    plan_blit(1);

    random_goal = queued_total + RANDOM_ITEMS;
    while (queued_total < random_goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: rop = ROP_COPY;
        4, 5, 6, 7, 8: rop = ROP_XOR;
        default: rop = 20'($urandom_range(0, 255));
      endcase
      set_regs({4'($urandom), 16'(($urandom_range(0, 7) == 0) ? $urandom_range(8, 40)
                                                             : $urandom_range(0, 7))},
               {4'($urandom), 16'(($urandom_range(0, 5) == 0) ? $urandom_range(6, 20)
                                                             : $urandom_range(0, 5))},
               pick_pitch(), pick_pitch(), 20'(pick_addr()), 20'(pick_addr()),
               20'($urandom_range(0, 255)), rop);
      burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 4)) noise_item();
        plan_blit($urandom_range(0, 3));
      end
    end

    settle(20);
    if (mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
